// ===== hdl/heartbeat_fault_annunciator_core_assert.svh =====
// Assertion macros shared by the heartbeat fault annunciator modules
`ifndef HEARTBEAT_FAULT_ANNUNCIATOR_CORE_ASSERT_SVH
`define HEARTBEAT_FAULT_ANNUNCIATOR_CORE_ASSERT_SVH

// check a condition at every clock edge outside reset
`define HFA_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// check a consequence in the cycle after the antecedent
`define HFA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/hfa_pkg.sv =====
// Package: shared types, constants and helpers of the heartbeat fault annunciator
package hfa_pkg;

	localparam int NUM_CHANNELS   = 8;
	localparam int NUM_EXCEPTIONS = 4;
	localparam int AGE_W          = 16;
	localparam int CH_W           = 3;
	localparam int EXC_W          = 4;
	localparam int TONE_W         = 5;
	localparam int BEEP_W         = 4;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 16;

	localparam logic [AGE_W-1:0] DEVICE_TIMEOUT_RST = 16'd200;
	localparam logic [AGE_W-1:0] BEEP_PERIOD_RST    = 16'd400;
	localparam logic [AGE_W-1:0] LINK_TIMEOUT_RST   = 16'd500;
	localparam logic [CH_W-1:0]  EXEMPT_RST         = 3'd0;

	typedef enum logic [1:0] {
		ACT_TICK    = 2'd0,
		ACT_CHAN_HB = 2'd1,
		ACT_LINK_HB = 2'd2,
		ACT_NONE    = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEVICE_TIMEOUT = 2'd0,
		REG_BEEP_PERIOD    = 2'd1,
		REG_LINK_TIMEOUT   = 2'd2,
		REG_EXEMPT_CHANNEL = 2'd3
	} cfg_reg_t;

	typedef logic [NUM_CHANNELS-1:0] mask_t;

	typedef struct packed {
		logic              fire;
		action_t           action;
		logic [CH_W-1:0]   channel;
		logic [EXC_W-1:0]  exception_flags;
		logic              switch_down;
		logic              startup_busy;
	} step_t;

	typedef struct packed {
		logic [AGE_W-1:0] device_timeout;
		logic [AGE_W-1:0] beep_period;
		logic [AGE_W-1:0] link_timeout;
		logic [CH_W-1:0]  exempt_channel;
	} cfg_t;

	typedef struct packed {
		logic              tone_request;
		logic              tone_silent;
		logic [TONE_W-1:0] tone_index;
		mask_t             offline_mask;
	} result_t;

	function automatic logic [AGE_W-1:0] sat_inc(input logic [AGE_W-1:0] v);
		return (v == {AGE_W{1'b1}}) ? v : v + {{(AGE_W-1){1'b0}}, 1'b1};
	endfunction

endpackage

// ===== hdl/hfa_channel_bank.sv =====
// Channel bank: per-channel heartbeat ages and the offline judgement
module hfa_channel_bank (
	input  logic           clk,
	input  logic           arst_n,
	input  hfa_pkg::step_t step,
	input  hfa_pkg::cfg_t  cfg,
	output hfa_pkg::mask_t mask
);
	import hfa_pkg::*;

	logic [AGE_W-1:0] age_q   [NUM_CHANNELS];
	logic [AGE_W-1:0] age_nxt [NUM_CHANNELS];

	always_comb begin
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			age_nxt[i] = age_q[i];
			case (step.action)
				ACT_TICK: begin
					age_nxt[i] = sat_inc(age_q[i]);
				end
				ACT_CHAN_HB: begin
					if (step.channel == CH_W'(i)) begin
						age_nxt[i] = '0;
					end
				end
				default: begin
					age_nxt[i] = age_q[i];
				end
			endcase
			mask[i] = (age_nxt[i] >= cfg.device_timeout) &&
				!(step.switch_down && (cfg.exempt_channel == CH_W'(i)));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				age_q[i] <= '0;
			end
		end else if (step.fire) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				age_q[i] <= age_nxt[i];
			end
		end
	end

endmodule

// ===== hdl/hfa_tone_ctrl.sv =====
// Tone control: link age, beep slot timing and tone command priority
`include "heartbeat_fault_annunciator_core_assert.svh"

module hfa_tone_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  hfa_pkg::step_t   step,
	input  hfa_pkg::cfg_t    cfg,
	input  hfa_pkg::mask_t   mask,
	output hfa_pkg::result_t res
);
	import hfa_pkg::*;

	logic [AGE_W-1:0]  link_q;
	logic [AGE_W-1:0]  slot_q;
	logic [BEEP_W-1:0] beep_q;

	logic [AGE_W-1:0]  link_nxt;
	logic [AGE_W-1:0]  slot_inc;
	logic              slot_end;
	logic              is_tick;
	logic [CH_W-1:0]   first;
	logic [1:0]        exc;
	logic              has_exc;
	logic              beep_mode;
	logic              beep_half;
	logic [BEEP_W:0]   beep_inc;
	logic [BEEP_W:0]   beep_lim;
	logic [BEEP_W-1:0] beep_nxt;

	always_comb begin
		is_tick  = (step.action == ACT_TICK);
		link_nxt = link_q;
		case (step.action)
			ACT_TICK:    link_nxt = sat_inc(link_q);
			ACT_LINK_HB: link_nxt = '0;
			default:     link_nxt = link_q;
		endcase
		slot_inc  = sat_inc(slot_q);
		slot_end  = slot_inc >= cfg.beep_period;
		beep_half = {1'b0, slot_inc, 1'b0} < {2'b00, cfg.beep_period};

		first = '0;
		for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
			if (mask[i]) begin
				first = CH_W'(i);
			end
		end
		exc     = '0;
		has_exc = 1'b0;
		for (int i = NUM_EXCEPTIONS - 1; i >= 0; i--) begin
			if (step.exception_flags[i]) begin
				exc     = 2'(i);
				has_exc = 1'b1;
			end
		end

		beep_inc = {1'b0, beep_q} + (BEEP_W+1)'(1);
		beep_lim = (BEEP_W+1)'(first) + (BEEP_W+1)'(2);
		beep_nxt = (beep_inc > beep_lim) ? '0 : beep_inc[BEEP_W-1:0];

		res              = '0;
		res.offline_mask = mask;
		beep_mode        = 1'b0;
		if (is_tick && !step.startup_busy) begin
			if (link_nxt > cfg.link_timeout) begin
				res.tone_request = 1'b1;
				res.tone_silent  = 1'b1;
			end else if (has_exc) begin
				res.tone_request = 1'b1;
				res.tone_index   = TONE_W'(exc);
			end else if (mask == '0) begin
				res.tone_request = 1'b1;
				res.tone_silent  = 1'b1;
			end else begin
				beep_mode = 1'b1;
				if (beep_half) begin
					res.tone_request = 1'b1;
					if ({1'b0, beep_q} <= (BEEP_W+1)'(first)) begin
						res.tone_index = TONE_W'(beep_q);
					end else begin
						res.tone_silent = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= '0;
			slot_q <= '0;
			beep_q <= '0;
		end else if (step.fire) begin
			link_q <= link_nxt;
			if (is_tick) begin
				slot_q <= slot_end ? '0 : slot_inc;
				if (beep_mode && slot_end) begin
					beep_q <= beep_nxt;
				end
			end
		end
	end

	`HFA_ASSERT_ALWAYS(a_idle_cmd_clean, res.tone_request || (!res.tone_silent && res.tone_index == '0), "tone fields set without a request")
	`HFA_ASSERT_ALWAYS(a_silence_no_note, !res.tone_silent || res.tone_index == '0, "silence carries a note")
	`HFA_ASSERT_NEXT(a_slot_wraps, step.fire && is_tick && slot_end, slot_q == '0, "slot phase did not wrap at slot end")

endmodule

// ===== hdl/hfa_out_buf.sv =====
// Output buffer: result register with a skid entry
`include "heartbeat_fault_annunciator_core_assert.svh"

module hfa_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  hfa_pkg::result_t push_data,
	output logic             full,
	output logic             out_valid,
	input  logic             out_stall,
	output hfa_pkg::result_t out_data
);
	import hfa_pkg::*;

	logic    main_valid_q;
	logic    skid_valid_q;
	result_t main_q;
	result_t skid_q;
	logic    pop;

	assign pop       = main_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!main_valid_q || pop) begin
			if (skid_valid_q) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_valid_q || pop) begin
			main_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	`HFA_ASSERT_ALWAYS(a_skid_behind_main, !skid_valid_q || main_valid_q, "skid entry held with empty result register")
	`HFA_ASSERT_NEXT(a_stall_holds, main_valid_q && out_stall, main_valid_q, "result dropped while stalled")
	`HFA_ASSERT_NEXT(a_push_to_skid, main_valid_q && out_stall && push, skid_valid_q, "transfer lost while result register stalled")

endmodule

// ===== hdl/heartbeat_fault_annunciator_core.sv =====
// Top level of the heartbeat fault annunciator
//
// Usage: every input transfer (in_valid high, in_stall low) carries one event:
// a one millisecond tick, a device channel heartbeat or a controller link
// heartbeat. Each transfer yields exactly one result on the output channel
// (out_valid, held until out_stall is low): the offline mask and, on ticks,
// a tone command (request, silence flag, note index).
// The result of a transfer is registered and shown from the cycle after
// acceptance unless the receiver stalls. Throughput is one transfer per cycle
// while in_stall is low; ages, offline compares and tone priority are combinational.
// When the receiver stalls, the result register holds and a skid entry takes
// one more transfer; in_stall rises only while that skid entry is occupied.
// Configuration: cfg_valid/cfg_ready write register cfg_index with cfg_data;
// cfg_ready is always high. Write only while no transfer is in flight.
// Reset (arst_n low) clears all ages, the slot phase and the beep counter,
// loads the default timeouts and empties the output buffer.
module heartbeat_fault_annunciator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    action,
	input  logic [hfa_pkg::CH_W-1:0]      channel,
	input  logic [hfa_pkg::EXC_W-1:0]     exception_flags,
	input  logic                          switch_down,
	input  logic                          startup_busy,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          tone_request,
	output logic                          tone_silent,
	output logic [hfa_pkg::TONE_W-1:0]    tone_index,
	output logic [hfa_pkg::NUM_CHANNELS-1:0] offline_mask,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [hfa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hfa_pkg::CFG_DATA_W-1:0] cfg_data
);
	import hfa_pkg::*;

	cfg_t    cfg_q;
	step_t   step;
	mask_t   mask;
	result_t res;
	result_t out_data;
	logic    full;

	assign cfg_ready = 1'b1;
	assign in_stall  = full;

	always_comb begin
		step.fire            = in_valid && !full;
		step.action          = action_t'(action);
		step.channel         = channel;
		step.exception_flags = exception_flags;
		step.switch_down     = switch_down;
		step.startup_busy    = startup_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_timeout <= DEVICE_TIMEOUT_RST;
			cfg_q.beep_period    <= BEEP_PERIOD_RST;
			cfg_q.link_timeout   <= LINK_TIMEOUT_RST;
			cfg_q.exempt_channel <= EXEMPT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_DEVICE_TIMEOUT: cfg_q.device_timeout <= cfg_data;
				REG_BEEP_PERIOD:    cfg_q.beep_period    <= cfg_data;
				REG_LINK_TIMEOUT:   cfg_q.link_timeout   <= cfg_data;
				REG_EXEMPT_CHANNEL: cfg_q.exempt_channel <= cfg_data[CH_W-1:0];
				default:            cfg_q <= cfg_q;
			endcase
		end
	end

	hfa_channel_bank u_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cfg    (cfg_q),
		.mask   (mask)
	);

	hfa_tone_ctrl u_tone (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cfg    (cfg_q),
		.mask   (mask),
		.res    (res)
	);

	hfa_out_buf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step.fire),
		.push_data (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign tone_request = out_data.tone_request;
	assign tone_silent  = out_data.tone_silent;
	assign tone_index   = out_data.tone_index;
	assign offline_mask = out_data.offline_mask;

endmodule
